FILE: rtl/assert_macros.svh
// Assertion macros included by the RTL top level.
// Relies on clk and rst_n being visible in the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pttc_pkg.sv
// Shared types and constants for the pressure/temperature compensation pipeline.
// No dependencies.
`timescale 1ns / 1ps

package pttc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMP_CAL    = 2'd0;
    localparam logic [1:0] CFG_PRESS_CAL_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_CAL_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_CAL_C = 2'd3;

    // Divisor offset, fine-temperature offset and numerator scale, applied before the final Q24.8 shift
    localparam logic [63:0] PRESS_BASE = 64'd1 << 47;
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] NUM_SCALE = 64'd3125;

    // Temperature coefficients handed to the fine-temperature stages
    typedef struct packed {
        logic signed [15:0] t3;
        logic signed [15:0] t2;
        logic        [15:0] t1;
    } temp_coef_t;

    function automatic logic [63:0] sx16_64(input logic [15:0] v);
        sx16_64 = {{48{v[15]}}, v};
    endfunction

endpackage

FILE: rtl/pttc_delay.sv
// Stall-aware delay line used for valid bits and side-band data.
// No dependencies.
`timescale 1ns / 1ps

module pttc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                tap_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: rtl/pttc_mul64.sv
// Two-stage multiplier giving the low 64 bits of a 64 x 64 product.
// Built from three 32 x 32 partial products; no dependencies.
`timescale 1ns / 1ps

module pttc_mul64 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;
    logic [63:0] lh_full;
    logic [63:0] hl_full;

    assign lh_full = a[31:0] * b[63:32];
    assign hl_full = a[63:32] * b[31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[31:0] * b[31:0];
            lh_reg <= lh_full[31:0];
            hl_reg <= hl_full[31:0];
            p_reg  <= ll_reg + {lh_reg + hl_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/pttc_div.sv
// Pipelined signed 64 / 32 divider, one quotient bit per stage, truncating.
// No dependencies.
`timescale 1ns / 1ps

module pttc_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [63:0] quo
);

    localparam int STEPS = 64;

    logic [63:0] x_reg   [STEPS+1];
    logic [31:0] rem_reg [STEPS+1];
    logic [31:0] md_reg  [STEPS+1];
    logic        neg_reg [STEPS+1];
    logic [63:0] x_next  [STEPS+1];
    logic [31:0] rem_next[STEPS+1];
    logic [63:0] quo_reg;

    // One restoring step per stage
    always_comb
    begin
        logic [32:0] r;
        logic        ge;
        x_next[0]   = '0;
        rem_next[0] = '0;
        for (int k = 1; k <= STEPS; k++)
        begin
            r  = {rem_reg[k-1], x_reg[k-1][63]};
            ge = (r >= {1'b0, md_reg[k-1]});
            rem_next[k] = ge ? 32'(r - {1'b0, md_reg[k-1]}) : r[31:0];
            x_next[k]   = {x_reg[k-1][62:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= num[63] ? (64'd0 - num) : num;
            md_reg[0]  <= den[31] ? (32'd0 - den) : den;
            neg_reg[0] <= num[63] ^ den[31];
            rem_reg[0] <= '0;
            for (int k = 1; k <= STEPS; k++)
            begin
                x_reg[k]   <= x_next[k];
                rem_reg[k] <= rem_next[k];
                md_reg[k]  <= md_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            quo_reg <= neg_reg[STEPS] ? (64'd0 - x_reg[STEPS]) : x_reg[STEPS];
        end
    end

    assign quo = quo_reg;

endmodule

FILE: rtl/pttc_temp.sv
// Four-stage fine temperature and saturated 0.01 degC temperature.
// Depends on pttc_pkg.
`timescale 1ns / 1ps

module pttc_temp
    import pttc_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [19:0]        raw_t,
    input  temp_coef_t         coef,
    output logic signed [15:0] temp_centi,
    output logic [63:0]        fine_off
);

    logic signed [17:0] d1;
    logic signed [17:0] d2;
    logic signed [33:0] m1_reg;
    logic signed [35:0] sq_reg;
    logic signed [22:0] v1_reg;
    logic signed [37:0] m2_reg;
    logic signed [31:0] fine_reg;
    logic signed [15:0] temp_reg;
    logic [63:0]        off_reg;
    logic signed [35:0] sq_shr;
    logic signed [34:0] f5;
    logic signed [34:0] t_full;
    logic signed [15:0] t_sat;

    assign d1 = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
    assign d2 = $signed({2'b0, raw_t[19:4]}) - $signed({2'b0, coef.t1});
    assign sq_shr = sq_reg >>> 12;

    assign f5     = fine_reg * 35'sd5 + 35'sd128;
    assign t_full = f5 >>> 8;

    always_comb
    begin
        if (t_full > 35'sd32767)
        begin
            t_sat = 16'sh7fff;
        end
        else if (t_full < -35'sd32768)
        begin
            t_sat = 16'sh8000;
        end
        else
        begin
            t_sat = t_full[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= d1 * coef.t2;
            sq_reg   <= d2 * d2;
            v1_reg   <= 23'(m1_reg >>> 11);
            m2_reg   <= $signed(sq_shr[21:0]) * coef.t3;
            fine_reg <= 32'(v1_reg) + 32'(m2_reg >>> 14);
            temp_reg <= t_sat;
            off_reg  <= {{32{fine_reg[31]}}, fine_reg} - FINE_OFFSET;
        end
    end

    assign temp_centi = temp_reg;
    assign fine_off   = off_reg;

endmodule

FILE: rtl/pressure_temperature_compensation.sv
// Top level of the pressure/temperature compensation pipeline.
// Depends on pttc_pkg, pttc_delay, pttc_mul64, pttc_div, pttc_temp, assert_macros.svh.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+--------------------------------------------------
//  input   | in_valid / in_stall | raw_temperature, raw_pressure
//  output  | out_valid/out_stall | temperature_centi, pressure_q24_8, pressure_valid
//  config  | cfg_write           | cfg_index, cfg_data
//
// One request is taken every cycle unless a stalled output result holds the pipeline;
// the depth is set mostly by the 64-step bit-serial quotient pipeline.
// Reset clears the valid delay line, the side-band delay lines and the calibration registers.
// A stalled result at the output freezes every stage; nothing is dropped or doubled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pressure_temperature_compensation
    import pttc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic               pressure_valid
);

    // Total depth from accepted request to output register
    localparam int LATENCY = 82;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;

    // Calibration registers; to be written only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg <= '0;
            press_a_reg  <= '0;
            press_b_reg  <= '0;
            press_c_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TEMP_CAL:    temp_cal_reg <= cfg_data[47:0];
                CFG_PRESS_CAL_A: press_a_reg  <= cfg_data;
                CFG_PRESS_CAL_B: press_b_reg  <= cfg_data;
                CFG_PRESS_CAL_C: press_c_reg  <= cfg_data[15:0];
                default:         press_c_reg  <= press_c_reg;
            endcase
        end
    end

    temp_coef_t  tcoef;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign tcoef.t1 = temp_cal_reg[15:0];
    assign tcoef.t2 = temp_cal_reg[31:16];
    assign tcoef.t3 = temp_cal_reg[47:32];
    assign p1 = {48'd0, press_a_reg[15:0]};
    assign p2 = sx16_64(press_a_reg[31:16]);
    assign p3 = sx16_64(press_a_reg[47:32]);
    assign p4 = sx16_64(press_a_reg[63:48]);
    assign p5 = sx16_64(press_b_reg[15:0]);
    assign p6 = sx16_64(press_b_reg[31:16]);
    assign p7 = sx16_64(press_b_reg[47:32]);
    assign p8 = sx16_64(press_b_reg[63:48]);
    assign p9 = sx16_64(press_c_reg);

    // Whole pipeline advances unless the output holds a stalled result
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    pttc_delay #(.WIDTH(1), .DEPTH(LATENCY)) u_vld (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(in_valid), .dout(out_valid)
    );

    // Stages 1-4: fine temperature, temperature, fine - 128000
    logic signed [15:0] temp_d4;
    logic [63:0]        vp_d4;

    pttc_temp u_temp (
        .clk(clk), .en(adv), .raw_t(raw_temperature), .coef(tcoef),
        .temp_centi(temp_d4), .fine_off(vp_d4)
    );

    // Pressure offset term rides alongside to stage 8
    logic [20:0] pd_in;
    logic [20:0] pd_d8;
    assign pd_in = 21'h100000 - {1'b0, raw_pressure};

    pttc_delay #(.WIDTH(21), .DEPTH(8)) u_pd (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(pd_in), .dout(pd_d8)
    );

    // Stages 5-6: v^2, v*P5, v*P2
    logic [63:0] vsq_d6, vp5_d6, vp2_d6;
    pttc_mul64 u_mul_sq (.clk(clk), .en(adv), .a(vp_d4), .b(vp_d4), .p(vsq_d6));
    pttc_mul64 u_mul_p5 (.clk(clk), .en(adv), .a(vp_d4), .b(p5), .p(vp5_d6));
    pttc_mul64 u_mul_p2 (.clk(clk), .en(adv), .a(vp_d4), .b(p2), .p(vp2_d6));

    // Stages 7-8: v^2*P6, v^2*P3
    logic [63:0] sq6_d8, sq3_d8, vp5_d8, vp2_d8;
    pttc_mul64 u_mul_p6 (.clk(clk), .en(adv), .a(vsq_d6), .b(p6), .p(sq6_d8));
    pttc_mul64 u_mul_p3 (.clk(clk), .en(adv), .a(vsq_d6), .b(p3), .p(sq3_d8));

    pttc_delay #(.WIDTH(128), .DEPTH(2)) u_lin (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .din({vp5_d6, vp2_d6}), .dout({vp5_d8, vp2_d8})
    );

    // Stage 9: divisor base and numerator before scaling
    logic [63:0] x_reg;
    logic [63:0] n0_reg;
    logic [63:0] sq3_shr;
    assign sq3_shr = $signed(sq3_d8) >>> 8;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg  <= sq3_shr + (vp2_d8 << 12) + PRESS_BASE;
            n0_reg <= {12'd0, pd_d8, 31'd0} - sq6_d8 - (vp5_d8 << 17) - (p4 << 35);
        end
    end

    // Stages 10-11: divisor and numerator products
    logic [63:0] dprod_d11, num_d11;
    pttc_mul64 u_mul_p1 (.clk(clk), .en(adv), .a(x_reg), .b(p1), .p(dprod_d11));
    pttc_mul64 u_mul_nm (.clk(clk), .en(adv), .a(n0_reg), .b(NUM_SCALE), .p(num_d11));

    // Divisor is the product shifted down 33, so it fits 31 bits signed
    logic [31:0] den_d11;
    logic        zero_d11;
    assign den_d11  = {dprod_d11[63], dprod_d11[63:33]};
    assign zero_d11 = (dprod_d11[63:33] == 31'd0);

    // Stages 12-77: quotient
    logic [63:0] p_d77;
    pttc_div u_div (.clk(clk), .en(adv), .num(num_d11), .den(den_d11), .quo(p_d77));

    // Stages 78-79: P9*(p>>13), P8*p
    logic [63:0] a_d77;
    logic [63:0] h_d79, i_d79, a_d79;
    assign a_d77 = $signed(p_d77) >>> 13;
    pttc_mul64 u_mul_p9 (.clk(clk), .en(adv), .a(p9), .b(a_d77), .p(h_d79));
    pttc_mul64 u_mul_p8 (.clk(clk), .en(adv), .a(p8), .b(p_d77), .p(i_d79));

    pttc_delay #(.WIDTH(64), .DEPTH(2)) u_a (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(a_d77), .dout(a_d79)
    );

    // Stages 80-81: quadratic term
    logic [63:0] j_d81, i_shr_d79, v2_d81, p_d81;
    assign i_shr_d79 = $signed(i_d79) >>> 19;
    pttc_mul64 u_mul_qd (.clk(clk), .en(adv), .a(h_d79), .b(a_d79), .p(j_d81));

    pttc_delay #(.WIDTH(64), .DEPTH(2)) u_v2 (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(i_shr_d79), .dout(v2_d81)
    );
    pttc_delay #(.WIDTH(64), .DEPTH(4)) u_p (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(p_d77), .dout(p_d81)
    );

    // Side band: temperature and zero-divisor flag ride to stage 81
    logic signed [15:0] temp_d81;
    logic               zero_d81;
    pttc_delay #(.WIDTH(16), .DEPTH(77)) u_tmp (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(temp_d4), .dout(temp_d81)
    );
    pttc_delay #(.WIDTH(1), .DEPTH(70)) u_zero (
        .clk(clk), .rst_n(rst_n), .en(adv), .din(zero_d11), .dout(zero_d81)
    );

    // Stage 82: final sum, Q24.8 shift, offset by P7
    // Shift each signed term on its own so the sum stays arithmetic
    logic [63:0] j_shr81, sum81, sum_shr81, fin81;
    assign j_shr81   = $signed(j_d81) >>> 25;
    assign sum81     = p_d81 + j_shr81 + v2_d81;
    assign sum_shr81 = $signed(sum81) >>> 8;
    assign fin81     = sum_shr81 + (p7 << 4);

    logic signed [15:0] temp_out_reg;
    logic [31:0]        press_out_reg;
    logic               pvalid_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp_out_reg   <= temp_d81;
            press_out_reg  <= zero_d81 ? 32'd0 : fin81[31:0];
            pvalid_out_reg <= !zero_d81;
        end
    end

    assign temperature_centi = temp_out_reg;
    assign pressure_q24_8    = press_out_reg;
    assign pressure_valid    = pvalid_out_reg;

    // A flagged result always carries zero pressure
    `ASSERT_IMPLIES(a_zero_div, out_valid && !pressure_valid, pressure_q24_8 == 32'd0, "flagged pressure not zero")
    // Input backpressure only comes from a held output result
    `ASSERT_IMPLIES(a_stall_src, in_stall, out_valid && out_stall, "input stalled without output stall")
    // A frozen pipeline keeps its temperature result
    `ASSERT_NEXT(a_hold_temp, out_valid && out_stall, $stable(temperature_centi), "temperature moved under stall")

endmodule
